FILE: design/fmpd_pkg.sv
// ----------------------------------------------------------------------------
// fmpd_pkg: shared constants for the fader motor position drive
// Operation codes, register indexes, direction codes and fixed field widths.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package fmpd_pkg;

  // default sizing handed to the top level
  localparam int FADER_COUNT_DEF = 8;
  localparam int SAMPLE_BITS_DEF = 10;

  // fixed field widths of the stream items
  localparam int OP_W     = 2;
  localparam int FADER_W  = 3;
  localparam int VALUE_W  = 10;
  localparam int POS_W    = 7;
  localparam int DIR_W    = 2;
  localparam int PWM_W    = 8;
  localparam int IN_TDATA_W  = 16;
  localparam int OUT_TDATA_W = 24;

  // configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 10;

  // mapping constants
  localparam int END_MARGIN = 4;
  localparam int FULL_SCALE = 100;

  // quotient bits produced by the serial divider
  localparam int QUO_W = 8;

  // operation codes
  localparam logic [OP_W-1:0] OP_SAMPLE   = 2'd0;
  localparam logic [OP_W-1:0] OP_SETPOINT = 2'd1;
  localparam logic [OP_W-1:0] OP_CAL_LOW  = 2'd2;
  localparam logic [OP_W-1:0] OP_CAL_HIGH = 2'd3;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_PWM   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_PWM   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SLOW_ZONE = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_FAST_ZONE = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_FB_SLOW   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_FB_FAST   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_TARGET_TOL = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_NOISE_TOL = 3'd7;

  // register reset values
  localparam logic [PWM_W-1:0]      MIN_PWM_RST    = 8'd60;
  localparam logic [PWM_W-1:0]      MAX_PWM_RST    = 8'd255;
  localparam logic [POS_W-1:0]      SLOW_ZONE_RST  = 7'd5;
  localparam logic [POS_W-1:0]      FAST_ZONE_RST  = 7'd30;
  localparam logic [POS_W-1:0]      TARGET_TOL_RST = 7'd1;
  localparam logic [VALUE_W-1:0]    NOISE_TOL_RST  = 10'd2;

  // motor direction codes
  localparam logic [DIR_W-1:0] DIR_STOP = 2'b00;
  localparam logic [DIR_W-1:0] DIR_UP   = 2'b01;
  localparam logic [DIR_W-1:0] DIR_DOWN = 2'b11;

endpackage

FILE: design/fmpd_div.sv
// ----------------------------------------------------------------------------
// fmpd_div: serial restoring divider
// Produces QUO_W quotient bits, one per cycle; the caller guarantees that
// the quotient fits, i.e. num_i < den_i * 2**QUO_W.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module fmpd_div #(
  parameter int NUM_W = fmpd_pkg::SAMPLE_BITS_DEF + 7,
  parameter int DEN_W = fmpd_pkg::SAMPLE_BITS_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [NUM_W-1:0]           num_i,
  input  logic [DEN_W-1:0]           den_i,
  output logic                       done_o,
  output logic [fmpd_pkg::QUO_W-1:0] quo_o
);

  localparam int QW    = fmpd_pkg::QUO_W;
  localparam int CNT_W = $clog2(QW);

  logic [DEN_W-1:0] rem_q;
  logic [DEN_W-1:0] den_q;
  logic [QW-1:0]    shf_q;
  logic [CNT_W-1:0] cnt_q;
  logic             busy_q;
  logic             done_q;

  logic [DEN_W:0]   trial;
  logic             fits;

  // bring down the next numerator bit and try the subtract
  assign trial = {rem_q, shf_q[QW-1]};
  assign fits  = trial >= {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + CNT_W'(1);
        if (cnt_q == CNT_W'(QW - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= DEN_W'(num_i >> QW);
      shf_q <= num_i[QW-1:0];
      den_q <= den_i;
    end else if (busy_q) begin
      rem_q <= fits ? DEN_W'(trial - {1'b0, den_q}) : trial[DEN_W-1:0];
      shf_q <= {shf_q[QW-2:0], fits};
    end
  end

  assign done_o = done_q;
  assign quo_o  = shf_q;

endmodule

FILE: design/fader_motor_position_drive.sv
// ----------------------------------------------------------------------------
// fader_motor_position_drive: per-fader motor drive for motorised faders
// A sample transaction (operation 0) carries one fader's raw ADC reading and
// the touch flag and yields one result: the fader's 0..100 position, motor
// direction, PWM duty and an at-target flag. Setpoint and calibration
// transactions (operations 1..3) update per-fader state and yield no result;
// transactions for a fader index not below FADER_COUNT are dropped. A sample
// runs through state read, position mapping, drive decision and result load;
// a reading on a calibration end skips the position scaling division and one
// needing no interpolated duty skips the duty interpolation division, both
// on the one shared serial divider, which produces one quotient bit per
// cycle. Setpoint and calibration transactions are written as they are
// accepted. The input is not ready while a sample is in work; a finished
// result waits in the output register, so the next transaction is accepted
// while it is still unclaimed. Per-fader state sits in small memories read
// at acceptance; entries never written read as their reset values through
// per-fader valid flags, so no clearing pass is needed after reset.
// Configuration writes are taken at any time but are meant for idle periods.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module fader_motor_position_drive #(
  parameter int FADER_COUNT = fmpd_pkg::FADER_COUNT_DEF,
  parameter int SAMPLE_BITS = fmpd_pkg::SAMPLE_BITS_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,

  // register write channel
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [fmpd_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [fmpd_pkg::CFG_DATA_W-1:0]     cfg_data_i,

  // input stream
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // [2:0] fader, [12:3] value, [13] touched, [15:14] zero
  input  logic [fmpd_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
  // [1:0] operation
  input  logic [fmpd_pkg::OP_W-1:0]           s_axis_tuser,

  // result stream
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // [2:0] fader_out, [9:3] position, [11:10] motor_direction,
  // [19:12] motor_pwm, [20] at_target, [23:21] zero
  output logic [fmpd_pkg::OUT_TDATA_W-1:0]    m_axis_tdata
);

  localparam int IDX_W  = (FADER_COUNT > 1) ? $clog2(FADER_COUNT) : 1;
  localparam int SW     = SAMPLE_BITS + 2;            // signed compare width
  localparam int NUM_W  = SAMPLE_BITS + 7;            // (raw - lo) * 100
  localparam int DEN_W  = SAMPLE_BITS;
  localparam int FW     = fmpd_pkg::FADER_W;
  localparam int VW     = fmpd_pkg::VALUE_W;
  localparam int PW     = fmpd_pkg::POS_W;
  localparam int MW     = fmpd_pkg::PWM_W;
  localparam int DW     = fmpd_pkg::DIR_W;
  localparam int PRD_W  = PW + MW;                    // zone offset * duty span
  localparam logic [SAMPLE_BITS-1:0] SAMPLE_MAX = {SAMPLE_BITS{1'b1}};
  localparam logic [PW-1:0] FULL_POS = PW'(fmpd_pkg::FULL_SCALE);

  // sequencer states
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_READ = 3'd1;
  localparam logic [2:0] S_POS  = 3'd2;
  localparam logic [2:0] S_PDIV = 3'd3;
  localparam logic [2:0] S_DRV  = 3'd4;
  localparam logic [2:0] S_WDIV = 3'd5;
  localparam logic [2:0] S_OUT  = 3'd6;

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [MW-1:0] min_pwm_q, max_pwm_q;
  logic [PW-1:0] slow_zone_q, fast_zone_q, fb_slow_q, fb_fast_q, target_tol_q;
  logic [VW-1:0] noise_tol_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_pwm_q    <= fmpd_pkg::MIN_PWM_RST;
      max_pwm_q    <= fmpd_pkg::MAX_PWM_RST;
      slow_zone_q  <= fmpd_pkg::SLOW_ZONE_RST;
      fast_zone_q  <= fmpd_pkg::FAST_ZONE_RST;
      fb_slow_q    <= fmpd_pkg::SLOW_ZONE_RST;
      fb_fast_q    <= fmpd_pkg::FAST_ZONE_RST;
      target_tol_q <= fmpd_pkg::TARGET_TOL_RST;
      noise_tol_q  <= fmpd_pkg::NOISE_TOL_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        fmpd_pkg::CFG_MIN_PWM:    min_pwm_q    <= cfg_data_i[MW-1:0];
        fmpd_pkg::CFG_MAX_PWM:    max_pwm_q    <= cfg_data_i[MW-1:0];
        fmpd_pkg::CFG_SLOW_ZONE:  slow_zone_q  <= cfg_data_i[PW-1:0];
        fmpd_pkg::CFG_FAST_ZONE:  fast_zone_q  <= cfg_data_i[PW-1:0];
        fmpd_pkg::CFG_FB_SLOW:    fb_slow_q    <= cfg_data_i[PW-1:0];
        fmpd_pkg::CFG_FB_FAST:    fb_fast_q    <= cfg_data_i[PW-1:0];
        fmpd_pkg::CFG_TARGET_TOL: target_tol_q <= cfg_data_i[PW-1:0];
        fmpd_pkg::CFG_NOISE_TOL:  noise_tol_q  <= cfg_data_i[VW-1:0];
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Input decode
  // --------------------------------------------------------------------------
  logic [2:0]               state_q, state_d;
  logic [FW-1:0]            in_fader;
  logic [VW-1:0]            in_value;
  logic                     in_touch;
  logic [FW+IDX_W-1:0]      in_fader_x;
  logic [IDX_W-1:0]         in_addr;
  logic [VW+SAMPLE_BITS-1:0] in_value_x;
  logic [SAMPLE_BITS-1:0]   in_val;
  logic [PW-1:0]            in_setpoint;
  logic                     in_acc, in_hit;
  logic                     wr_tgt, wr_lo, wr_hi, start_sample;

  assign in_fader   = s_axis_tdata[FW-1:0];
  assign in_value   = s_axis_tdata[FW+VW-1:FW];
  assign in_touch   = s_axis_tdata[FW+VW];
  assign in_fader_x = {{IDX_W{1'b0}}, in_fader};
  assign in_addr    = in_fader_x[IDX_W-1:0];
  // mask or widen the raw value to the sample width
  assign in_value_x = {{SAMPLE_BITS{1'b0}}, in_value};
  assign in_val     = in_value_x[SAMPLE_BITS-1:0];
  // saturate the setpoint to full scale
  assign in_setpoint = (in_val > SAMPLE_BITS'(fmpd_pkg::FULL_SCALE)) ?
                       FULL_POS : in_val[PW-1:0];

  assign s_axis_tready = (state_q == S_IDLE);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  // drop transactions for faders that do not exist
  assign in_hit        = in_acc && (int'(in_fader) < FADER_COUNT);
  assign wr_tgt        = in_hit && (s_axis_tuser == fmpd_pkg::OP_SETPOINT);
  assign wr_lo         = in_hit && (s_axis_tuser == fmpd_pkg::OP_CAL_LOW);
  assign wr_hi         = in_hit && (s_axis_tuser == fmpd_pkg::OP_CAL_HIGH);
  assign start_sample  = in_hit && (s_axis_tuser == fmpd_pkg::OP_SAMPLE);

  // --------------------------------------------------------------------------
  // Per-fader state: memories plus valid flags standing in for reset values
  // --------------------------------------------------------------------------
  logic [SAMPLE_BITS-1:0] held_mem [FADER_COUNT];
  logic [PW-1:0]          tgt_mem  [FADER_COUNT];
  logic [SAMPLE_BITS-1:0] lo_mem   [FADER_COUNT];
  logic [SAMPLE_BITS-1:0] hi_mem   [FADER_COUNT];

  logic [FADER_COUNT-1:0] held_vld_q, tgt_vld_q, lo_vld_q, hi_vld_q;
  logic [SAMPLE_BITS-1:0] held_rd_q, lo_rd_q, hi_rd_q;
  logic [PW-1:0]          tgt_rd_q;

  // item registers
  logic [FW-1:0]          fad_q;
  logic [IDX_W-1:0]       addr_q;
  logic [SAMPLE_BITS-1:0] val_q;
  logic                   touch_q;

  // held sample update
  logic                   held_vld;
  logic [SAMPLE_BITS-1:0] held_cur;
  logic [SAMPLE_BITS-1:0] jitter;
  logic                   take_new;
  logic                   held_wr;

  assign held_vld = held_vld_q[addr_q];
  assign held_cur = held_rd_q;
  assign jitter   = (val_q > held_cur) ? (val_q - held_cur) : (held_cur - val_q);
  // the first reading is always taken; later ones only beyond the jitter band
  assign take_new = !held_vld ||
                    ({{VW{1'b0}}, jitter} > {{SAMPLE_BITS{1'b0}}, noise_tol_q});
  assign held_wr  = (state_q == S_READ) && take_new;

  always_ff @(posedge clk_i) begin
    if (held_wr) held_mem[addr_q] <= val_q;
    if (start_sample) held_rd_q <= held_mem[in_addr];
  end

  always_ff @(posedge clk_i) begin
    if (wr_tgt) tgt_mem[in_addr] <= in_setpoint;
    if (start_sample) tgt_rd_q <= tgt_mem[in_addr];
  end

  always_ff @(posedge clk_i) begin
    if (wr_lo) lo_mem[in_addr] <= in_val;
    if (start_sample) lo_rd_q <= lo_mem[in_addr];
  end

  always_ff @(posedge clk_i) begin
    if (wr_hi) hi_mem[in_addr] <= in_val;
    if (start_sample) hi_rd_q <= hi_mem[in_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_vld_q <= '0;
      tgt_vld_q  <= '0;
      lo_vld_q   <= '0;
      hi_vld_q   <= '0;
    end else begin
      if (held_wr) held_vld_q[addr_q] <= 1'b1;
      if (wr_tgt)  tgt_vld_q[in_addr] <= 1'b1;
      if (wr_lo)   lo_vld_q[in_addr]  <= 1'b1;
      if (wr_hi)   hi_vld_q[in_addr]  <= 1'b1;
    end
  end

  // hold the sample item while it is in work
  always_ff @(posedge clk_i) begin
    if (start_sample) begin
      fad_q   <= in_fader;
      addr_q  <= in_addr;
      val_q   <= in_val;
      touch_q <= in_touch;
    end
  end

  // --------------------------------------------------------------------------
  // Working registers, loaded in S_READ
  // --------------------------------------------------------------------------
  logic [SAMPLE_BITS-1:0] raw_q, lo_q, hi_q;
  logic [PW-1:0]          tgt_q;

  always_ff @(posedge clk_i) begin
    if (state_q == S_READ) begin
      raw_q <= take_new ? val_q : held_cur;
      lo_q  <= lo_vld_q[addr_q] ? lo_rd_q : '0;
      hi_q  <= hi_vld_q[addr_q] ? hi_rd_q : SAMPLE_MAX;
      tgt_q <= tgt_vld_q[addr_q] ? tgt_rd_q : '0;
    end
  end

  // --------------------------------------------------------------------------
  // Position mapping (S_POS)
  // --------------------------------------------------------------------------
  logic signed [SW-1:0]   raw_x, lo_x, hi_x;
  logic                   at_low_end, at_high_end;
  logic [SAMPLE_BITS-1:0] pos_off, pos_span;
  logic [NUM_W-1:0]       pos_num;

  assign raw_x = $signed({2'b00, raw_q});
  assign lo_x  = $signed({2'b00, lo_q});
  assign hi_x  = $signed({2'b00, hi_q});
  // the low end is tested first, so a reading that meets both ends reads as zero
  assign at_low_end  = raw_x <= (lo_x + SW'(fmpd_pkg::END_MARGIN));
  assign at_high_end = raw_x >= (hi_x - SW'(fmpd_pkg::END_MARGIN));
  // between the ends lo < raw < hi, so both differences are positive
  assign pos_off  = raw_q - lo_q;
  assign pos_span = hi_q - lo_q;
  assign pos_num  = NUM_W'(pos_off) * NUM_W'(fmpd_pkg::FULL_SCALE);

  // --------------------------------------------------------------------------
  // Drive decision (S_DRV)
  // --------------------------------------------------------------------------
  logic [PW-1:0]        pos_q;
  logic signed [PW:0]   diff;
  logic [PW-1:0]        err_mag;
  logic                 move;
  logic [PW-1:0]        slow_c, fast_c, slow_e, fast_e;
  logic                 zones_bad;
  logic [PW-1:0]        zone_off, zone_span;
  logic                 duty_down;
  logic [MW-1:0]        duty_span;
  logic [PRD_W-1:0]     pwm_num;

  assign diff    = $signed({1'b0, tgt_q}) - $signed({1'b0, pos_q});
  assign err_mag = diff[PW] ? PW'(-diff) : diff[PW-1:0];
  assign move    = (err_mag > target_tol_q) && !touch_q;

  // clamp the zones to full scale, fall back when fast does not exceed slow
  assign slow_c    = (slow_zone_q > FULL_POS) ? FULL_POS : slow_zone_q;
  assign fast_c    = (fast_zone_q > FULL_POS) ? FULL_POS : fast_zone_q;
  assign zones_bad = fast_c <= slow_c;
  assign slow_e    = zones_bad ? fb_slow_q : slow_c;
  assign fast_e    = zones_bad ? fb_fast_q : fast_c;

  // interpolation only runs with slow_e < err_mag < fast_e
  assign zone_off  = err_mag - slow_e;
  assign zone_span = fast_e - slow_e;
  assign duty_down = max_pwm_q < min_pwm_q;
  assign duty_span = duty_down ? (min_pwm_q - max_pwm_q) : (max_pwm_q - min_pwm_q);
  assign pwm_num   = PRD_W'(zone_off) * PRD_W'(duty_span);

  // --------------------------------------------------------------------------
  // Shared divider
  // --------------------------------------------------------------------------
  logic                        div_start;
  logic [NUM_W-1:0]            div_num;
  logic [DEN_W-1:0]            div_den;
  logic                        div_done;
  logic [fmpd_pkg::QUO_W-1:0]  div_quo;
  logic                        interp;

  assign interp    = move && (err_mag < fast_e) && (err_mag > slow_e);
  assign div_start = ((state_q == S_POS) && !at_low_end && !at_high_end) ||
                     ((state_q == S_DRV) && interp);
  assign div_num   = (state_q == S_POS) ? pos_num : NUM_W'(pwm_num);
  assign div_den   = (state_q == S_POS) ? pos_span : DEN_W'(zone_span);

  fmpd_div #(
    .NUM_W (NUM_W),
    .DEN_W (DEN_W)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .done_o  (div_done),
    .quo_o   (div_quo)
  );

  // --------------------------------------------------------------------------
  // Sequencer
  // --------------------------------------------------------------------------
  logic          out_load;
  logic          m_valid_q;
  logic [DW-1:0] dir_q;
  logic [MW-1:0] pwm_q;
  logic          at_q;
  logic          down_q;

  assign out_load = (state_q == S_OUT) && (!m_valid_q || m_axis_tready);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: if (start_sample) state_d = S_READ;
      S_READ: state_d = S_POS;
      S_POS:  state_d = div_start ? S_PDIV : S_DRV;
      S_PDIV: if (div_done) state_d = S_DRV;
      S_DRV:  state_d = div_start ? S_WDIV : S_OUT;
      S_WDIV: if (div_done) state_d = S_OUT;
      S_OUT:  if (out_load) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // position, direction and duty
  always_ff @(posedge clk_i) begin
    if (state_q == S_POS) begin
      if (at_low_end) begin
        pos_q <= '0;
      end else if (at_high_end) begin
        pos_q <= FULL_POS;
      end
    end else if ((state_q == S_PDIV) && div_done) begin
      pos_q <= div_quo[PW-1:0];
    end

    if (state_q == S_DRV) begin
      at_q   <= !move;
      down_q <= duty_down;
      if (!move) begin
        dir_q <= fmpd_pkg::DIR_STOP;
        pwm_q <= '0;
      end else begin
        dir_q <= diff[PW] ? fmpd_pkg::DIR_DOWN : fmpd_pkg::DIR_UP;
        if (err_mag >= fast_e) begin
          pwm_q <= max_pwm_q;
        end else if (err_mag <= slow_e) begin
          pwm_q <= min_pwm_q;
        end
      end
    end else if ((state_q == S_WDIV) && div_done) begin
      // quotient is truncated toward zero on the magnitude
      pwm_q <= down_q ? (min_pwm_q - div_quo) : (min_pwm_q + div_quo);
    end
  end

  // --------------------------------------------------------------------------
  // Output register
  // --------------------------------------------------------------------------
  logic [FW-1:0] out_fad_q;
  logic [PW-1:0] out_pos_q;
  logic [DW-1:0] out_dir_q;
  logic [MW-1:0] out_pwm_q;
  logic          out_at_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (out_load) begin
      m_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_fad_q <= fad_q;
      out_pos_q <= pos_q;
      out_dir_q <= dir_q;
      out_pwm_q <= pwm_q;
      out_at_q  <= at_q;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {3'b000, out_at_q, out_pwm_q, out_dir_q, out_pos_q, out_fad_q};

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_div_start_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_start |-> (state_q == S_POS || state_q == S_DRV))
    else $error("divider started outside a mapping or drive step");

  a_div_done_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> (state_q == S_PDIV || state_q == S_WDIV))
    else $error("divider finished while no division was awaited");

  a_stop_no_duty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_valid_q && out_dir_q == fmpd_pkg::DIR_STOP) |-> (out_pwm_q == '0))
    else $error("duty given with the motor stopped");

  a_target_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_valid_q |-> (out_at_q == (out_dir_q == fmpd_pkg::DIR_STOP)))
    else $error("at-target flag disagrees with direction");

  a_pos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_valid_q |-> (out_pos_q <= FULL_POS))
    else $error("position above full scale");

  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |=> (m_valid_q && state_q == S_IDLE))
    else $error("result load did not present a result and free the input");

endmodule

FILE: tb/tb_fader_motor_position_drive.sv
// ----------------------------------------------------------------------------
// tb_fader_motor_position_drive: self-checking bench for the fader motor drive
// Walks a short table of directed transactions, then about 1200 random ones
// over several register settings. Results are predicted per fader in the
// bench and compared field by field, in order, with the result stream.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_fader_motor_position_drive;

  import fmpd_pkg::*;

  localparam int FADER_TOTAL = 8;
  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_WAIT  = 30;
  localparam int PHASES      = 10;
  localparam int ITEMS_PER_PHASE = 120;

  typedef struct packed {
    logic [FADER_W-1:0] fader;
    logic [POS_W-1:0]   position;
    logic [DIR_W-1:0]   direction;
    logic [PWM_W-1:0]   pwm;
    logic               at_target;
  } drive_result_t;

  typedef struct {
    logic [OP_W-1:0]    op;
    logic [FADER_W-1:0] fader;
    logic [VALUE_W-1:0] value;
    bit                 touched;
    bit                 typed;
    drive_result_t      want;
  } stim_row_t;

  logic                   clk_i;
  logic                   rst_ni;
  logic                   cfg_valid_i;
  logic                   cfg_ready_o;
  logic [CFG_IDX_W-1:0]   cfg_index_i;
  logic [CFG_DATA_W-1:0]  cfg_data_i;
  logic                   s_axis_tvalid;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata;   // [2:0] fader, [12:3] value, [13] touched
  logic [OP_W-1:0]        s_axis_tuser;   // [1:0] operation
  logic                   m_axis_tvalid;
  logic                   m_axis_tready;
  // [2:0] fader_out, [9:3] position, [11:10] direction, [19:12] pwm, [20] at_target
  logic [OUT_TDATA_W-1:0] m_axis_tdata;

  // copy of the block's registers
  logic [PWM_W-1:0]   reg_min_pwm;
  logic [PWM_W-1:0]   reg_max_pwm;
  logic [POS_W-1:0]   reg_slow_zone;
  logic [POS_W-1:0]   reg_fast_zone;
  logic [POS_W-1:0]   reg_fb_slow;
  logic [POS_W-1:0]   reg_fb_fast;
  logic [POS_W-1:0]   reg_target_tol;
  logic [VALUE_W-1:0] reg_noise_tol;

  // copy of the per-fader state
  logic [VALUE_W-1:0] held_raw    [FADER_TOTAL];
  bit                 held_seen   [FADER_TOTAL];
  logic [POS_W-1:0]   setpoint_pos[FADER_TOTAL];
  logic [VALUE_W-1:0] cal_lo      [FADER_TOTAL];
  logic [VALUE_W-1:0] cal_hi      [FADER_TOTAL];

  drive_result_t pending_drive_q[$];
  stim_row_t     directed_rows[$];
  int            mismatch_count;
  int            cycle_count;
  int            idle_pct;
  int            stall_pct;

  fader_motor_position_drive dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  // 8 ns clock
  initial clk_i = 1'b0;
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Hard stop in case the stream hangs.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Restore the register and fader state that follows reset.
  function automatic void reset_drive_state();
    reg_min_pwm    = MIN_PWM_RST;
    reg_max_pwm    = MAX_PWM_RST;
    reg_slow_zone  = SLOW_ZONE_RST;
    reg_fast_zone  = FAST_ZONE_RST;
    reg_fb_slow    = SLOW_ZONE_RST;
    reg_fb_fast    = FAST_ZONE_RST;
    reg_target_tol = TARGET_TOL_RST;
    reg_noise_tol  = NOISE_TOL_RST;
    for (int i = 0; i < FADER_TOTAL; i++) begin
      held_raw[i]     = '0;
      held_seen[i]    = 1'b0;
      setpoint_pos[i] = '0;
      cal_lo[i]       = '0;
      cal_hi[i]       = '1;
    end
  endfunction

  // Registers keep only their own width of the written data.
  function automatic void apply_register(logic [CFG_IDX_W-1:0] idx,
                                         logic [CFG_DATA_W-1:0] data);
    case (idx)
      CFG_MIN_PWM:    reg_min_pwm    = data[PWM_W-1:0];
      CFG_MAX_PWM:    reg_max_pwm    = data[PWM_W-1:0];
      CFG_SLOW_ZONE:  reg_slow_zone  = data[POS_W-1:0];
      CFG_FAST_ZONE:  reg_fast_zone  = data[POS_W-1:0];
      CFG_FB_SLOW:    reg_fb_slow    = data[POS_W-1:0];
      CFG_FB_FAST:    reg_fb_fast    = data[POS_W-1:0];
      CFG_TARGET_TOL: reg_target_tol = data[POS_W-1:0];
      CFG_NOISE_TOL:  reg_noise_tol  = data[VALUE_W-1:0];
      default: ;
    endcase
  endfunction

  // Update the fader state for one transaction and work out the drive it
  // yields. Returns 1 only for samples, the one operation with a result.
  function automatic bit predict_drive(input logic [OP_W-1:0] op,
                                       input logic [FADER_W-1:0] f,
                                       input logic [VALUE_W-1:0] v,
                                       input bit touched,
                                       output drive_result_t r);
    int delta, raw, lo, hi, pos, diff, err_mag;
    int s, fz, plo, phi, pwm;
    r = '0;
    case (op)
      OP_SETPOINT: begin
        setpoint_pos[f] = (v > FULL_SCALE) ? POS_W'(FULL_SCALE) : v[POS_W-1:0];
        return 1'b0;
      end
      OP_CAL_LOW: begin
        cal_lo[f] = v;
        return 1'b0;
      end
      OP_CAL_HIGH: begin
        cal_hi[f] = v;
        return 1'b0;
      end
      default: ;
    endcase

    // first reading is taken as it is, later ones must clear the jitter band
    if (held_seen[f]) begin
      delta = (v > held_raw[f]) ? int'(v - held_raw[f]) : int'(held_raw[f] - v);
      if (delta > int'(reg_noise_tol))
        held_raw[f] = v;
    end else begin
      held_raw[f]  = v;
      held_seen[f] = 1'b1;
    end

    // scale to 0..100, the low end clamp decides first
    raw = int'(held_raw[f]);
    lo  = int'(cal_lo[f]);
    hi  = int'(cal_hi[f]);
    if (raw <= lo + END_MARGIN)
      pos = 0;
    else if (raw >= hi - END_MARGIN)
      pos = FULL_SCALE;
    else begin
      pos = ((raw - lo) * FULL_SCALE) / (hi - lo);
      if (pos < 0) pos = 0;
      if (pos > FULL_SCALE) pos = FULL_SCALE;
    end

    diff    = int'(setpoint_pos[f]) - pos;
    err_mag = (diff < 0) ? -diff : diff;
    r.fader    = f;
    r.position = pos[POS_W-1:0];
    if (err_mag > int'(reg_target_tol) && !touched) begin
      r.direction = (diff > 0) ? DIR_UP : DIR_DOWN;
      s   = int'(reg_slow_zone);
      fz  = int'(reg_fast_zone);
      plo = int'(reg_min_pwm);
      phi = int'(reg_max_pwm);
      if (s > FULL_SCALE) s = FULL_SCALE;
      if (fz > FULL_SCALE) fz = FULL_SCALE;
      // bad zones fall back; the fallback pair is taken unclamped
      if (fz <= s) begin
        s  = int'(reg_fb_slow);
        fz = int'(reg_fb_fast);
      end
      if (err_mag >= fz)
        pwm = phi;
      else if (err_mag <= s)
        pwm = plo;
      else
        pwm = plo + ((err_mag - s) * (phi - plo)) / (fz - s);
      r.pwm       = pwm[PWM_W-1:0];
      r.at_target = 1'b0;
    end else begin
      r.direction = DIR_STOP;
      r.pwm       = '0;
      r.at_target = 1'b1;
    end
    return 1'b1;
  endfunction

  // Present one transaction and hold it until the block takes it. The valid
  // stays high on return so that the next transaction follows without a gap.
  task automatic send_item(input logic [OP_W-1:0] op, input logic [FADER_W-1:0] f,
                           input logic [VALUE_W-1:0] v, input bit touched,
                           input bit use_typed, input drive_result_t typed);
    drive_result_t predicted;
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= {2'b00, touched, v, f};
    do @(posedge clk_i); while (!s_axis_tready);
    if (predict_drive(op, f, v, touched, predicted))
      pending_drive_q.push_back(use_typed ? typed : predicted);
  endtask

  // Random gap on the sending side after a transaction.
  task automatic sender_gap();
    if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk_i);
    end
  endtask

  // Drop valid, wait for every expected result and let the block settle.
  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    while (pending_drive_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);
  endtask

  // Write all eight registers back to back, index i carrying settings[i].
  task automatic write_registers(input logic [CFG_DATA_W-1:0] settings [8]);
    logic [CFG_IDX_W-1:0] idx;
    cfg_valid_i <= 1'b1;
    for (int i = 0; i < 8; i++) begin
      idx = CFG_IDX_W'(i);
      cfg_index_i <= idx;
      cfg_data_i  <= settings[i];
      do @(posedge clk_i); while (!cfg_ready_o);
      apply_register(idx, settings[i]);
    end
    cfg_valid_i <= 1'b0;
  endtask

  task automatic add_row(input logic [OP_W-1:0] op, input int f, input int v,
                         input bit touched, input bit typed, input int pos,
                         input logic [DIR_W-1:0] dir, input int pwm, input bit at);
    stim_row_t row;
    row.op                 = op;
    row.fader              = FADER_W'(f);
    row.value              = VALUE_W'(v);
    row.touched            = touched;
    row.typed              = typed;
    row.want.fader         = FADER_W'(f);
    row.want.position      = POS_W'(pos);
    row.want.direction     = dir;
    row.want.pwm           = PWM_W'(pwm);
    row.want.at_target     = at;
    directed_rows.push_back(row);
  endtask

  // One random transaction, mostly samples, with values steered towards the
  // jitter band and the calibration ends so that the edge cases come up often.
  task automatic random_item();
    logic [OP_W-1:0]    op;
    logic [FADER_W-1:0] f;
    int                 v;
    int                 pick;
    bit                 touched;
    f       = FADER_W'($urandom_range(0, FADER_TOTAL - 1));
    pick    = $urandom_range(0, 99);
    touched = 1'b0;
    if (pick < 70) begin
      op = OP_SAMPLE;
      touched = ($urandom_range(0, 7) == 0);
      case ($urandom_range(0, 3))
        0: v = int'(held_raw[f]) + $urandom_range(0, 2 * int'(reg_noise_tol) + 2)
               - int'(reg_noise_tol) - 1;
        1: v = int'(cal_lo[f]) + $urandom_range(0, 12) - 6;
        2: v = int'(cal_hi[f]) + $urandom_range(0, 12) - 6;
        default: v = $urandom_range(0, 1023);
      endcase
      if (v < 0) v = 0;
      if (v > 1023) v = 1023;
    end else if (pick < 82) begin
      op = OP_SETPOINT;
      v  = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 1023) : $urandom_range(0, 100);
    end else if (pick < 91) begin
      op = OP_CAL_LOW;
      v  = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 1023) : $urandom_range(0, 200);
    end else begin
      op = OP_CAL_HIGH;
      v  = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 1023)
                                       : $urandom_range(800, 1023);
    end
    send_item(op, f, VALUE_W'(v), touched, 1'b0, '0);
  endtask

  // Receiving side: claim results, stalling in random bursts.
  initial begin
    m_axis_tready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (stall_pct != 0 && $urandom_range(0, 99) < stall_pct) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 11)) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
    end
  end

  // Compare each claimed result with the oldest expectation.
  always @(posedge clk_i) begin
    drive_result_t want;
    drive_result_t got;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.fader     = m_axis_tdata[2:0];
      got.position  = m_axis_tdata[9:3];
      got.direction = m_axis_tdata[11:10];
      got.pwm       = m_axis_tdata[19:12];
      got.at_target = m_axis_tdata[20];
      if (pending_drive_q.size() == 0) begin
        $display("%0t: result with none expected, actual tdata %h", $time, m_axis_tdata);
        mismatch_count++;
      end else begin
        want = pending_drive_q.pop_front();
        if (got.fader !== want.fader) begin
          $display("%0t: fader_out expected %0d actual %0d", $time, want.fader, got.fader);
          mismatch_count++;
        end
        if (got.position !== want.position) begin
          $display("%0t: position expected %0d actual %0d", $time,
                   want.position, got.position);
          mismatch_count++;
        end
        if (got.direction !== want.direction) begin
          $display("%0t: motor_direction expected %0d actual %0d", $time,
                   $signed(want.direction), $signed(got.direction));
          mismatch_count++;
        end
        if (got.pwm !== want.pwm) begin
          $display("%0t: motor_pwm expected %0d actual %0d", $time, want.pwm, got.pwm);
          mismatch_count++;
        end
        if (got.at_target !== want.at_target) begin
          $display("%0t: at_target expected %0d actual %0d", $time,
                   want.at_target, got.at_target);
          mismatch_count++;
        end
      end
    end
  end

  initial begin
    logic [CFG_DATA_W-1:0] settings [8];
    mismatch_count = 0;
    cycle_count    = 0;
    idle_pct       = 20;
    stall_pct      = 20;
    reset_drive_state();
    rst_ni        <= 1'b0;
    cfg_valid_i   <= 1'b0;
    cfg_index_i   <= '0;
    cfg_data_i    <= '0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= OP_SAMPLE;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed table, run under the reset settings. Typed rows can be read
    // straight off the behaviour; the rest go through the predictor.
    // first sample of a fader, everything at zero
    add_row(OP_SAMPLE, 0, 0, 0, 1, 0, DIR_STOP, 0, 1);
    // full-scale reading against a zero setpoint drives down at full duty
    add_row(OP_SAMPLE, 1, 1023, 0, 1, 100, DIR_DOWN, 255, 0);
    // a touched fader stops wherever it is
    add_row(OP_SAMPLE, 2, 1023, 1, 1, 100, DIR_STOP, 0, 1);
    // setpoint above full scale saturates
    add_row(OP_SETPOINT, 3, 1023, 0, 0, 0, DIR_STOP, 0, 0);
    add_row(OP_SAMPLE, 3, 0, 0, 1, 0, DIR_UP, 255, 0);
    // change within the jitter band is ignored, just outside it is taken
    add_row(OP_SAMPLE, 3, 2, 0, 1, 0, DIR_UP, 255, 0);
    add_row(OP_SAMPLE, 3, 3, 0, 1, 0, DIR_UP, 255, 0);
    add_row(OP_SAMPLE, 3, 512, 0, 0, 0, DIR_STOP, 0, 0);
    // calibrated fader: clamps at both ends, then interior points
    add_row(OP_SETPOINT, 4, 50, 0, 0, 0, DIR_STOP, 0, 0);
    add_row(OP_CAL_LOW, 4, 200, 0, 0, 0, DIR_STOP, 0, 0);
    add_row(OP_CAL_HIGH, 4, 800, 0, 0, 0, DIR_STOP, 0, 0);
    add_row(OP_SAMPLE, 4, 204, 0, 1, 0, DIR_UP, 255, 0);
    add_row(OP_SAMPLE, 4, 796, 0, 1, 100, DIR_DOWN, 255, 0);
    add_row(OP_SAMPLE, 4, 500, 0, 0, 0, DIR_STOP, 0, 0);
    add_row(OP_SAMPLE, 4, 560, 0, 0, 0, DIR_STOP, 0, 0);
    // reversed calibration: the low end clamp wins
    add_row(OP_CAL_LOW, 5, 800, 0, 0, 0, DIR_STOP, 0, 0);
    add_row(OP_CAL_HIGH, 5, 200, 0, 0, 0, DIR_STOP, 0, 0);
    add_row(OP_SAMPLE, 5, 500, 0, 1, 0, DIR_STOP, 0, 1);
    // narrow calibration
    add_row(OP_CAL_LOW, 6, 500, 0, 0, 0, DIR_STOP, 0, 0);
    add_row(OP_CAL_HIGH, 6, 505, 0, 0, 0, DIR_STOP, 0, 0);
    add_row(OP_SAMPLE, 6, 503, 0, 0, 0, DIR_STOP, 0, 0);
    add_row(OP_SAMPLE, 6, 1023, 0, 0, 0, DIR_STOP, 0, 0);
    // far from the setpoint but touched
    add_row(OP_SETPOINT, 7, 100, 0, 0, 0, DIR_STOP, 0, 0);
    add_row(OP_SAMPLE, 7, 0, 1, 1, 0, DIR_STOP, 0, 1);
    add_row(OP_SAMPLE, 7, 1000, 0, 0, 0, DIR_STOP, 0, 0);
    foreach (directed_rows[i]) begin
      send_item(directed_rows[i].op, directed_rows[i].fader, directed_rows[i].value,
                directed_rows[i].touched, directed_rows[i].typed, directed_rows[i].want);
      sender_gap();
    end

    // Random phases, each under its own register settings. Phase 0 keeps
    // the reset values; the last runs with no idling on either side.
    for (int ph = 0; ph < PHASES; ph++) begin
      if (ph != 0) begin
        drain_results();
        case (ph)
          1: settings = '{10'd0, 10'd0, 10'd0, 10'd0, 10'd0, 10'd0, 10'd0, 10'd0};
          2: settings = '{10'd255, 10'd255, 10'd100, 10'd100,
                          10'd100, 10'd100, 10'd100, 10'd1023};
          // duty falls as the distance grows
          3: settings = '{10'd200, 10'd20, 10'd3, 10'd60, 10'd5, 10'd30, 10'd2, 10'd4};
          // bad zones, usable fallback
          4: settings = '{10'd40, 10'd230, 10'd50, 10'd20, 10'd8, 10'd45, 10'd1, 10'd1};
          // zones over full scale clamp to a bad pair, fallback bad as well
          5: settings = '{10'd30, 10'd250, 10'd127, 10'd110, 10'd90, 10'd12, 10'd3, 10'd3};
          // full data width, the block keeps only each register's bits
          6, 7: foreach (settings[i]) settings[i] = CFG_DATA_W'($urandom_range(0, 1023));
          default: begin
            settings[0] = CFG_DATA_W'($urandom_range(0, 255));
            settings[1] = CFG_DATA_W'($urandom_range(0, 255));
            settings[2] = CFG_DATA_W'($urandom_range(0, 40));
            settings[3] = CFG_DATA_W'($urandom_range(10, 100));
            settings[4] = CFG_DATA_W'($urandom_range(0, 30));
            settings[5] = CFG_DATA_W'($urandom_range(20, 100));
            settings[6] = CFG_DATA_W'($urandom_range(0, 6));
            settings[7] = CFG_DATA_W'($urandom_range(0, 8));
          end
        endcase
        write_registers(settings);
        @(posedge clk_i);
      end
      if (ph == PHASES - 1) begin
        idle_pct  = 0;
        stall_pct = 0;
      end else begin
        // vary the pressure, with some phases running gap-free
        idle_pct  = 20 * $urandom_range(0, 3);
        stall_pct = 20 * $urandom_range(0, 3);
      end
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        random_item();
        sender_gap();
      end
    end

    drain_results();
    if (mismatch_count == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule
